/* hw/rtl/box_blur_3x3_edge_clamped_unit_macros.svh */
// Assertion macros shared by the box blur checker.
`ifndef BOX_BLUR_3X3_EDGE_CLAMPED_UNIT_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_CLAMPED_UNIT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define BB3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bb3_pkg.sv */
// Shared constants and types of the 3x3 box blur.
`default_nettype none

package bb3_pkg;

  localparam int MAX_DIM          = 1024;
  localparam int CHANNEL_BITS     = 16;
  localparam int PORT_CH_W        = 16;
  localparam int POS_W            = 10;
  localparam int SIZE_W           = 11;
  localparam int IMAGE_SIZE_RESET = 1024;

  // Result slots of one pixel, in raster order of the results
  localparam int N_OUT   = 4;
  localparam int SLOT_A0 = 0;  // row r-1, column c-1
  localparam int SLOT_A1 = 1;  // row r-1, column c
  localparam int SLOT_B0 = 2;  // row r, column c-1
  localparam int SLOT_B1 = 3;  // row r, column c

  typedef struct packed {
    logic [N_OUT-1:0] mask;
    logic             r2;
    logic             r1;
    logic             c2;
    logic             c1;
  } ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/bb3_pix_if.sv */
// Pixel input channel.
`default_nettype none

interface bb3_pix_if;
  logic                           valid;
  logic                           ready;
  logic [bb3_pkg::PORT_CH_W-1:0]  in_red;
  logic [bb3_pkg::PORT_CH_W-1:0]  in_green;
  logic [bb3_pkg::PORT_CH_W-1:0]  in_blue;

  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink   (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bb3_res_if.sv */
// Blurred pixel result channel.
`default_nettype none

interface bb3_res_if;
  logic                           valid;
  logic                           ready;
  logic [bb3_pkg::PORT_CH_W-1:0]  out_red;
  logic [bb3_pkg::PORT_CH_W-1:0]  out_green;
  logic [bb3_pkg::PORT_CH_W-1:0]  out_blue;
  logic [bb3_pkg::POS_W-1:0]      out_row;
  logic [bb3_pkg::POS_W-1:0]      out_col;
  logic                           run_last;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_row, output out_col, output run_last, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input out_row, input out_col, input run_last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bb3_line_buf.sv */
// Two line buffers in one memory, with write-to-read forwarding.
`default_nettype none

module bb3_line_buf #(
  parameter int DEPTH = bb3_pkg::MAX_DIM,
  parameter int AW    = 10,
  parameter int PW    = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [PW-1:0] wr_top_i,
  input  logic [PW-1:0] wr_mid_i,
  output logic [PW-1:0] rd_top_o,
  output logic [PW-1:0] rd_mid_o
);

  logic [2*PW-1:0] mem_q [DEPTH];
  logic [2*PW-1:0] rdata_q;
  logic [2*PW-1:0] fwd_data_q;
  logic            fwd_q;

  // Write back the shifted column, read the next one
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_top_i, wr_mid_i};
    end
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_data_q <= {wr_top_i, wr_mid_i};
    end
  end

  // Note a read that hits the entry written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign {rd_top_o, rd_mid_o} = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/bb3_emit.sv */
// Result sequencer: one neighbourhood sum per cycle, while the scaler takes them, from the column sums of a pixel.
`default_nettype none

module bb3_emit #(
  parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS,
  parameter int CNT_W        = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  bb3_pkg::ctl_t         ctl_i,
  input  logic [CNT_W-1:0]      row_i,
  input  logic [CNT_W-1:0]      col_i,
  input  logic [CHANNEL_BITS+1:0] va_i [3][3],
  input  logic [CHANNEL_BITS+1:0] vb_i [3][3],
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHANNEL_BITS+3:0] out_sum_o [3],
  output logic [1:0]            out_rows_o,
  output logic [1:0]            out_cols_o,
  output logic [CNT_W-1:0]      out_row_o,
  output logic [CNT_W-1:0]      out_col_o,
  output logic                  out_last_o
);

  localparam int VW = CHANNEL_BITS + 2;
  localparam int SW = CHANNEL_BITS + 4;
  localparam int NO = bb3_pkg::N_OUT;

  logic [NO-1:0]    pend_q, pend_d, sel;
  logic             r2_q, r1_q, c2_q, c1_q;
  logic [CNT_W-1:0] row_q, col_q;
  logic [VW-1:0]    va_q [3][3];
  logic [VW-1:0]    vb_q [3][3];
  logic             is_b, is_c, in_fire, out_fire;

  // Pick the earliest pending result
  assign sel  = pend_q & (~pend_q + NO'(1));
  assign is_b = sel[bb3_pkg::SLOT_B0] | sel[bb3_pkg::SLOT_B1];
  assign is_c = sel[bb3_pkg::SLOT_A1] | sel[bb3_pkg::SLOT_B1];

  assign out_valid_o = (pend_q != '0);
  assign out_last_o  = ((pend_q & ~sel) == '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (pend_q == '0) || (out_ready_i && out_last_o);
  assign in_fire     = in_valid_i && in_ready_o;

  // Add the columns of the chosen result
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (is_c) begin
        out_sum_o[k] = (c1_q ? SW'(is_b ? vb_q[1][k] : va_q[1][k]) : '0)
                     + SW'(is_b ? vb_q[2][k] : va_q[2][k]);
      end else begin
        out_sum_o[k] = (c2_q ? SW'(is_b ? vb_q[0][k] : va_q[0][k]) : '0)
                     + SW'(is_b ? vb_q[1][k] : va_q[1][k])
                     + SW'(is_b ? vb_q[2][k] : va_q[2][k]);
      end
    end
  end

  assign out_rows_o = is_b ? (r1_q ? 2'd2 : 2'd1) : (r2_q ? 2'd3 : 2'd2);
  assign out_cols_o = is_c ? (c1_q ? 2'd2 : 2'd1) : (c2_q ? 2'd3 : 2'd2);
  assign out_row_o  = is_b ? row_q : row_q - CNT_W'(1);
  assign out_col_o  = is_c ? col_q : col_q - CNT_W'(1);

  // Drop each result as it leaves, load the next pixel's set
  always_comb begin
    pend_d = pend_q;
    if (out_fire) begin
      pend_d = pend_q & ~sel;
    end
    if (in_fire) begin
      pend_d = ctl_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Hold the column sums of the pixel in service
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      r2_q  <= ctl_i.r2;
      r1_q  <= ctl_i.r1;
      c2_q  <= ctl_i.c2;
      c1_q  <= ctl_i.c1;
      row_q <= row_i;
      col_q <= col_i;
      va_q  <= va_i;
      vb_q  <= vb_i;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bb3_scale.sv */
// Mean by reciprocal multiply: divisor select stage, then product register.
`default_nettype none

module bb3_scale #(
  parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS,
  parameter int CNT_W        = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CHANNEL_BITS+3:0] sum_i [3],
  input  logic [1:0]              rows_i,
  input  logic [1:0]              cols_i,
  input  logic [CNT_W-1:0]        row_i,
  input  logic [CNT_W-1:0]        col_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [CHANNEL_BITS-1:0] quot_o [3],
  output logic [CNT_W-1:0]        row_o,
  output logic [CNT_W-1:0]        col_o,
  output logic                    last_o
);

  localparam int     SW   = CHANNEL_BITS + 4;
  localparam int     SH   = SW + 4;
  localparam int     MW   = SH + 1;
  localparam int     PRW  = SW + MW;
  localparam longint ONE  = longint'(1) << SH;
  localparam logic [MW-1:0] RCP1 = MW'(ONE);
  localparam logic [MW-1:0] RCP2 = MW'(ONE / 2);
  localparam logic [MW-1:0] RCP3 = MW'((ONE + 2) / 3);
  localparam logic [MW-1:0] RCP4 = MW'(ONE / 4);
  localparam logic [MW-1:0] RCP6 = MW'((ONE + 5) / 6);
  localparam logic [MW-1:0] RCP9 = MW'((ONE + 8) / 9);

  logic             s3_v_q, s4_v_q, s4_free, s3_adv;
  logic [SW-1:0]    sum_q [3];
  logic [1:0]       rows_q, cols_q;
  logic [CNT_W-1:0] row3_q, col3_q, row4_q, col4_q;
  logic             last3_q, last4_q;
  logic [3:0]       div;
  logic [MW-1:0]    recip;
  logic [PRW-1:0]   prod_q [3];

  assign s4_free    = !s4_v_q || out_ready_i;
  assign s3_adv     = s3_v_q && s4_free;
  assign in_ready_o = !s3_v_q || s4_free;

  // Look up the reciprocal of the neighbour count
  assign div = {2'b00, rows_q} * {2'b00, cols_q};
  always_comb begin
    case (div)
      4'd2:    recip = RCP2;
      4'd3:    recip = RCP3;
      4'd4:    recip = RCP4;
      4'd6:    recip = RCP6;
      4'd9:    recip = RCP9;
      default: recip = RCP1;
    endcase
  end

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s3_v_q <= 1'b1;
      end else if (s3_adv) begin
        s3_v_q <= 1'b0;
      end
      if (s3_adv) begin
        s4_v_q <= 1'b1;
      end else if (out_ready_i) begin
        s4_v_q <= 1'b0;
      end
    end
  end

  // Hold the sums, then the products
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sum_q   <= sum_i;
      rows_q  <= rows_i;
      cols_q  <= cols_i;
      row3_q  <= row_i;
      col3_q  <= col_i;
      last3_q <= last_i;
    end
    if (s3_adv) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= PRW'(sum_q[k]) * PRW'(recip);
      end
      row4_q  <= row3_q;
      col4_q  <= col3_q;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o = s4_v_q;
  assign row_o       = row4_q;
  assign col_o       = col4_q;
  assign last_o      = last4_q;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot_o[k] = prod_q[k][SH +: CHANNEL_BITS];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/box_blur_3x3_edge_clamped_unit.sv */
// Top level of the 3x3 edge-clamped box blur.
//
//   channel  dir  beat                                  taken when
//   pix_i    in   in_red, in_green, in_blue            valid && ready
//   res_o    out  out_red/green/blue, row, col, last   valid && ready
//   cfg      in   cfg_wdata_i (image size)             cfg_we_i
//
// One pixel is taken per cycle while the gather stage can pass it on. Results leave
// at one per cycle through the sequencer while the scaler takes them, so a pixel that
// closes two or four neighbourhoods (last column, last row) holds intake until its
// extra results have left. Line buffer reads and write-backs use one memory port
// pair, one column per pixel. Reset needs no clearing pass.
`default_nettype none

module box_blur_3x3_edge_clamped_unit #(
  parameter int MAX_DIM      = bb3_pkg::MAX_DIM,
  parameter int CHANNEL_BITS = bb3_pkg::CHANNEL_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bb3_pkg::SIZE_W-1:0] cfg_wdata_i,
  bb3_pix_if.sink                    pix_i,
  bb3_res_if.source                  res_o
);

  localparam int CNT_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CB      = CHANNEL_BITS;
  localparam int PW      = 3 * CB;
  localparam int VW      = CB + 2;
  localparam int SW      = CB + 4;
  localparam int OCW     = bb3_pkg::PORT_CH_W;
  localparam int OPW     = bb3_pkg::POS_W;
  localparam int RST_DIM = (bb3_pkg::IMAGE_SIZE_RESET < MAX_DIM) ?
                           bb3_pkg::IMAGE_SIZE_RESET : MAX_DIM;

  logic [CNT_W-1:0] last_q, last_d, row_q, row_d, col_q, col_d;
  logic             accept, s1_v_q, s1_adv, s1_ready;
  logic [PW-1:0]    pix_in, s1_pix_q, top, mid;
  logic [CNT_W-1:0] s1_r_q, s1_c_q;
  bb3_pkg::ctl_t    ctl_in, s1_ctl_q;
  logic [PW-1:0]    win_q [6];
  logic [PW-1:0]    cells [3][3];
  logic [VW-1:0]    va [3][3];
  logic [VW-1:0]    vb [3][3];
  logic             em_ready, em_valid, sc_ready, sc_valid, em_last, sc_last;
  logic [SW-1:0]    em_sum [3];
  logic [1:0]       em_rows, em_cols;
  logic [CNT_W-1:0] em_row, em_col, sc_row, sc_col;
  logic [CB-1:0]    quot [3];

  assign accept       = pix_i.valid && pix_i.ready;
  assign pix_i.ready  = s1_ready;
  assign pix_in       = {pix_i.in_blue[CB-1:0], pix_i.in_green[CB-1:0], pix_i.in_red[CB-1:0]};

  // Restart the frame on a size write, otherwise step through raster order
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    last_d = last_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
      if (cfg_wdata_i == '0) begin
        last_d = '0;
      end else if (32'(cfg_wdata_i) > 32'(MAX_DIM)) begin
        last_d = CNT_W'(MAX_DIM - 1);
      end else begin
        last_d = CNT_W'(32'(cfg_wdata_i) - 32'd1);
      end
    end else if (accept) begin
      if (col_q == last_q) begin
        col_d = '0;
        row_d = (row_q == last_q) ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      last_q <= CNT_W'(RST_DIM - 1);
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      last_q <= last_d;
    end
  end

  // Work out which neighbourhoods this pixel closes
  always_comb begin
    ctl_in.r1 = (row_q != '0);
    ctl_in.r2 = (row_q > CNT_W'(1));
    ctl_in.c1 = (col_q != '0);
    ctl_in.c2 = (col_q > CNT_W'(1));
    ctl_in.mask = '0;
    ctl_in.mask[bb3_pkg::SLOT_A0] = ctl_in.r1 && ctl_in.c1;
    ctl_in.mask[bb3_pkg::SLOT_A1] = ctl_in.r1 && (col_q == last_q);
    ctl_in.mask[bb3_pkg::SLOT_B0] = (row_q == last_q) && ctl_in.c1;
    ctl_in.mask[bb3_pkg::SLOT_B1] = (row_q == last_q) && (col_q == last_q);
  end

  bb3_line_buf #(
    .DEPTH (MAX_DIM),
    .AW    (CNT_W),
    .PW    (PW)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (s1_adv),
    .wr_addr_i (s1_c_q),
    .wr_top_i  (mid),
    .wr_mid_i  (s1_pix_q),
    .rd_top_o  (top),
    .rd_mid_o  (mid)
  );

  // Gather stage: the pixel waits here for its column from the line buffers
  assign s1_adv   = s1_v_q && ((s1_ctl_q.mask == '0) || em_ready);
  assign s1_ready = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q <= pix_in;
      s1_r_q   <= row_q;
      s1_c_q   <= col_q;
      s1_ctl_q <= ctl_in;
    end
  end

  // Shift the new column into the window
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k]     <= win_q[3 + k];
        win_q[3 + k] <= cells[2][k];
      end
    end
  end

  // Sum each window column over the rows of both result rows
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cells[0][k] = win_q[k];
      cells[1][k] = win_q[3 + k];
    end
    cells[2][0] = top;
    cells[2][1] = mid;
    cells[2][2] = s1_pix_q;
    for (int dc = 0; dc < 3; dc++) begin
      for (int k = 0; k < 3; k++) begin
        va[dc][k] = (s1_ctl_q.r2 ? VW'(cells[dc][0][k*CB +: CB]) : '0)
                  + VW'(cells[dc][1][k*CB +: CB]) + VW'(cells[dc][2][k*CB +: CB]);
        vb[dc][k] = (s1_ctl_q.r1 ? VW'(cells[dc][1][k*CB +: CB]) : '0)
                  + VW'(cells[dc][2][k*CB +: CB]);
      end
    end
  end

  bb3_emit #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .CNT_W        (CNT_W)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_v_q && (s1_ctl_q.mask != '0)),
    .in_ready_o  (em_ready),
    .ctl_i       (s1_ctl_q),
    .row_i       (s1_r_q),
    .col_i       (s1_c_q),
    .va_i        (va),
    .vb_i        (vb),
    .out_valid_o (em_valid),
    .out_ready_i (sc_ready),
    .out_sum_o   (em_sum),
    .out_rows_o  (em_rows),
    .out_cols_o  (em_cols),
    .out_row_o   (em_row),
    .out_col_o   (em_col),
    .out_last_o  (em_last)
  );

  bb3_scale #(
    .CHANNEL_BITS (CHANNEL_BITS),
    .CNT_W        (CNT_W)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (em_valid),
    .in_ready_o  (sc_ready),
    .sum_i       (em_sum),
    .rows_i      (em_rows),
    .cols_i      (em_cols),
    .row_i       (em_row),
    .col_i       (em_col),
    .last_i      (em_last),
    .out_valid_o (sc_valid),
    .out_ready_i (res_o.ready),
    .quot_o      (quot),
    .row_o       (sc_row),
    .col_o       (sc_col),
    .last_o      (sc_last)
  );

  // Drive the result beat
  assign res_o.valid     = sc_valid;
  assign res_o.out_red   = OCW'(quot[0]);
  assign res_o.out_green = OCW'(quot[1]);
  assign res_o.out_blue  = OCW'(quot[2]);
  assign res_o.out_row   = OPW'(sc_row);
  assign res_o.out_col   = OPW'(sc_col);
  assign res_o.run_last  = sc_last;

endmodule

`default_nettype wire

/* hw/rtl/bb3_checker.sv */
// Port-level checks of the box blur, bound to the top level.
`default_nettype none
`include "box_blur_3x3_edge_clamped_unit_macros.svh"

module bb3_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        pix_ready_i,
  input wire        res_valid_i,
  input wire        res_ready_i,
  input wire [68:0] res_data_i
);

  // A stalled result beat stays offered
  `BB3_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result beat withdrawn")

  // A stalled result beat keeps its payload
  `BB3_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(res_data_i), "result payload changed under stall")

  // Nothing is offered straight out of reset
  `BB3_ASSERT_SAME(a_res_quiet, !$past(rst_ni), !res_valid_i, "result offered after reset")

  // The pipe is empty out of reset, so intake is open
  `BB3_ASSERT_SAME(a_pix_open, !$past(rst_ni), pix_ready_i, "pixel intake closed after reset")

endmodule

bind box_blur_3x3_edge_clamped_unit bb3_checker u_bb3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_ready_i (pix_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  ({res_o.out_red, res_o.out_green, res_o.out_blue,
                 res_o.out_row, res_o.out_col, res_o.run_last})
);

`default_nettype wire
